// ----- hdl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = MAX_SLOTS / WORD_BITS;
    localparam int WORD_W    = $clog2(NUM_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int SIZE_W    = 9;
    localparam int OFS_W     = 18;
    localparam int SIZE_MAX  = 256;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_DFREE = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_COUNT = 1'b0,
        CFG_SIZE  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_DONE
    } state_t;

    // result of the shared word unit
    typedef struct packed {
        logic                 full;
        logic [BIT_W-1:0]     sel_bit;
        logic [WORD_BITS-1:0] set_word;
        logic [WORD_BITS-1:0] clr_word;
        logic                 free_hit;
    } word_res_t;

endpackage

// ----- hdl/bsa_word_unit.sv -----
// ----------------------------------------------------------------------------
// bsa_word_unit
// Shared bitmap word unit: picks the bit to allocate in one word and forms
// the updated word for an allocate or a free.
// ----------------------------------------------------------------------------
module bsa_word_unit (
    input  logic [bsa_pkg::WORD_BITS-1:0] word,
    input  logic                          use_hint,
    input  logic [bsa_pkg::BIT_W-1:0]     hint_bit,
    input  logic [bsa_pkg::BIT_W-1:0]     free_bit,
    output bsa_pkg::word_res_t            res
);
    import bsa_pkg::*;

    logic [BIT_W-1:0] first_clear;
    logic [BIT_W-1:0] pick;

    // lowest clear bit among all but the top one; top bit when none
    always_comb
    begin
        first_clear = BIT_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 2; i >= 0; i--)
        begin
            if (!word[i])
            begin
                first_clear = BIT_W'(i);
            end
        end
    end

    assign pick = (use_hint && !word[hint_bit]) ? hint_bit : first_clear;

    always_comb
    begin
        res.full     = &word;
        res.sel_bit  = pick;
        res.set_word = word | (WORD_BITS'(1) << pick);
        res.clr_word = word & ~(WORD_BITS'(1) << free_bit);
        res.free_hit = word[free_bit];
    end

endmodule

// ----- hdl/bitmap_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Fixed-slot allocator over an occupancy bitmap kept in a 32 x 32 memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per request. tuser[0] = mode (0 allocate, 1 free),
//   tdata[9:0] = slot to free. m_axis: one result beat per request.
//   cfg: write object_count (index 0) or object_size (index 1) while idle;
//   writing object_count re-initializes the bitmap, hints and in-use count.
// Timing:
//   A request goes from accept through S_LOOK (free, or allocate served
//   from the hinted word) to S_DONE; a free of an out-of-range slot skips
//   S_LOOK. An allocate whose hinted word is full scans on through S_SCAN
//   up to the last word in use, one word per cycle, as set by the single
//   read port of the bitmap memory feeding the shared word unit.
//   s_axis_tready is high only between requests; a finished result sits
//   in the output register, so the next request is taken while it waits.
//   If the receiver stalls with a result still held, the next result waits
//   in the sequencer until the output register frees up.
// Reset:
//   object_count = 1024, object_size = 1, all slots free, hints zero.
//   Per-word valid flags make unwritten words read as their reset value,
//   so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bsa_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [9:0] slot_index
    input  logic [0:0]                     s_axis_tuser,  // [0] mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [9:0] granted_index, [27:10] byte_offset, [29:28] status,
    // [40:30] used_count, [47:41] zero
    output logic [bsa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic [bsa_pkg::CNT_W-1:0]      cfg_data
);
    import bsa_pkg::*;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [NUM_WORDS-1:0]   valid_reg, valid_next;
    logic [WORD_W-1:0]      hint_word_reg, hint_word_next;
    logic [BIT_W-1:0]       hint_bit_reg, hint_bit_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic                   mode_reg, mode_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [IDX_W-1:0]       granted_reg, granted_next;
    status_t                status_reg, status_next;

    logic                   out_valid_reg;
    logic [IDX_W-1:0]       out_idx_reg;
    logic [OFS_W-1:0]       out_ofs_reg;
    status_t                out_stat_reg;
    logic [CNT_W-1:0]       out_used_reg;
    logic                   out_load;

    logic [WORD_BITS-1:0]   mem [NUM_WORDS];
    logic [WORD_BITS-1:0]   rd_data_reg;
    logic [WORD_W-1:0]      rd_addr_reg, rd_addr_next;
    logic                   wr_en;
    logic [WORD_W-1:0]      wr_addr;
    logic [WORD_BITS-1:0]   wr_data;

    logic [CNT_W-1:0]       cnt_eff;
    logic [SIZE_W-1:0]      size_eff;
    logic [WORD_W-1:0]      last_word;
    logic [CNT_W-1:0]       cnt_m1;
    logic [WORD_W-1:0]      hw_clamp;
    logic [WORD_BITS-1:0]   pad_word;
    logic [WORD_BITS-1:0]   word_eff;
    logic [WORD_W:0]        next_t;
    logic                   s_accept;
    logic                   cfg_accept;
    logic [IDX_W+SIZE_W-1:0] product;
    word_res_t              res;

    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);

    always_comb
    begin
        if (count_reg == '0)
            cnt_eff = CNT_W'(1);
        else if (count_reg > CNT_W'(MAX_SLOTS))
            cnt_eff = CNT_W'(MAX_SLOTS);
        else
            cnt_eff = count_reg;
        if (size_reg == '0)
            size_eff = SIZE_W'(1);
        else if (size_reg > SIZE_W'(SIZE_MAX))
            size_eff = SIZE_W'(SIZE_MAX);
        else
            size_eff = size_reg;
    end

    assign cnt_m1    = cnt_eff - CNT_W'(1);
    assign last_word = cnt_m1[BIT_W +: WORD_W];
    assign hw_clamp  = (hint_word_reg > last_word) ? last_word : hint_word_reg;

    // slots at or above the count read as occupied in unwritten words
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            pad_word[b] = ({1'b0, rd_addr_reg, BIT_W'(b)} >= cnt_eff);
        end
    end

    assign word_eff = valid_reg[rd_addr_reg] ? rd_data_reg : pad_word;
    assign next_t   = {1'b0, rd_addr_reg} + (WORD_W+1)'(1);

    bsa_word_unit u_word (
        .word     (word_eff),
        .use_hint (state_reg == S_LOOK),
        .hint_bit (hint_bit_reg),
        .free_bit (slot_reg[BIT_W-1:0]),
        .res      (res)
    );

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr_next];
        rd_addr_reg <= rd_addr_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        size_next      = size_reg;
        valid_next     = valid_reg;
        hint_word_next = hint_word_reg;
        hint_bit_next  = hint_bit_reg;
        used_next      = used_reg;
        mode_next      = mode_reg;
        slot_next      = slot_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        rd_addr_next   = rd_addr_reg;
        wr_en          = 1'b0;
        wr_addr        = rd_addr_reg;
        wr_data        = res.set_word;
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    hint_word_next = hw_clamp;
                    mode_next      = s_axis_tuser[0];
                    slot_next      = s_axis_tdata[IDX_W-1:0];
                    granted_next   = '0;
                    status_next    = STAT_OK;
                    if (s_axis_tuser[0])
                    begin
                        if ({1'b0, s_axis_tdata[IDX_W-1:0]} >= cnt_eff)
                        begin
                            status_next = STAT_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            rd_addr_next = s_axis_tdata[BIT_W +: WORD_W];
                            state_next   = S_LOOK;
                        end
                    end
                    else
                    begin
                        rd_addr_next = hw_clamp;
                        state_next   = S_LOOK;
                    end
                end
                if (cfg_accept)
                begin
                    case (cfg_idx_t'(cfg_index))
                        CFG_COUNT:
                        begin
                            count_next     = cfg_data;
                            valid_next     = '0;
                            hint_word_next = '0;
                            hint_bit_next  = '0;
                            used_next      = '0;
                        end
                        CFG_SIZE:
                        begin
                            size_next = cfg_data[SIZE_W-1:0];
                        end
                        default:
                        begin
                            size_next = size_reg;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                if (mode_reg)
                begin
                    if (!res.free_hit)
                    begin
                        status_next = STAT_DFREE;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = res.clr_word;
                        valid_next[rd_addr_reg] = 1'b1;
                        if (rd_addr_reg < hint_word_reg)
                            hint_word_next = rd_addr_reg;
                        if (slot_reg[BIT_W-1:0] < hint_bit_reg)
                            hint_bit_next = slot_reg[BIT_W-1:0];
                        if (used_reg != '0)
                            used_next = used_reg - CNT_W'(1);
                        granted_next = slot_reg;
                    end
                    state_next = S_DONE;
                end
                else if (!res.full)
                begin
                    wr_en = 1'b1;
                    valid_next[rd_addr_reg] = 1'b1;
                    granted_next = {rd_addr_reg, res.sel_bit};
                    if (hint_bit_reg < BIT_W'(WORD_BITS - 2))
                        hint_bit_next = hint_bit_reg + BIT_W'(1);
                    used_next  = used_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else if (next_t > {1'b0, last_word})
                begin
                    status_next    = STAT_FULL;
                    hint_word_next = last_word;
                    state_next     = S_DONE;
                end
                else
                begin
                    rd_addr_next = next_t[WORD_W-1:0];
                    state_next   = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (!res.full)
                begin
                    wr_en = 1'b1;
                    valid_next[rd_addr_reg] = 1'b1;
                    granted_next = {rd_addr_reg, res.sel_bit};
                    if (res.sel_bit == BIT_W'(WORD_BITS - 1))
                    begin
                        // hint moves past a word that just filled up
                        hint_bit_next = '0;
                        if (rd_addr_reg == last_word)
                            hint_word_next = last_word;
                        else
                            hint_word_next = next_t[WORD_W-1:0];
                    end
                    else
                    begin
                        hint_bit_next  = res.sel_bit + BIT_W'(1);
                        hint_word_next = rd_addr_reg;
                    end
                    used_next  = used_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else if (next_t > {1'b0, last_word})
                begin
                    status_next    = STAT_FULL;
                    hint_word_next = last_word;
                    state_next     = S_DONE;
                end
                else
                begin
                    rd_addr_next = next_t[WORD_W-1:0];
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_W'(MAX_SLOTS);
            size_reg      <= SIZE_W'(1);
            valid_reg     <= '0;
            hint_word_reg <= '0;
            hint_bit_reg  <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            size_reg      <= size_next;
            valid_reg     <= valid_next;
            hint_word_reg <= hint_word_next;
            hint_bit_reg  <= hint_bit_next;
            used_reg      <= used_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign product = granted_reg * size_eff;

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        slot_reg    <= slot_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
        if (out_load)
        begin
            out_idx_reg  <= granted_reg;
            out_ofs_reg  <= (status_reg == STAT_OK) ? product[OFS_W-1:0] : '0;
            out_stat_reg <= status_reg;
            out_used_reg <= used_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - IDX_W - OFS_W - 2 - CNT_W){1'b0}},
                            out_used_reg, out_stat_reg, out_ofs_reg, out_idx_reg};

endmodule

// ----- hdl/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks for the bitmap slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bsa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           cfg_ready
);
    import bsa_pkg::*;

    // held result beat must not change under backpressure
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // a request leaves the sequencer busy in the next cycle, with neither input ready
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !cfg_ready))
        else $error("ready after accepting a request");

    // failed requests report no slot and no offset
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[29:28] != STAT_OK))
            |-> (m_axis_tdata[27:0] == '0))
        else $error("nonzero slot on failed request");

    // in-use count never exceeds the slot total
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[40:30] <= CNT_W'(MAX_SLOTS)))
        else $error("in-use count above slot total");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
